/* sv/block_nested_loop_equijoin_macros.svh */
// Assertion macros shared by the join engine.
`ifndef BLOCK_NESTED_LOOP_EQUIJOIN_MACROS_SVH
`define BLOCK_NESTED_LOOP_EQUIJOIN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNLJ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bnlj assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BNLJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bnlj assertion failed");

`endif

/* sv/bnlj_pkg.sv */
package bnlj_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_PROBE = 2'd2;

   localparam int RID_W = 31;
   localparam int KEY_W = 32;

   typedef struct packed {
      logic clear;
      logic load;
      logic probe;
      logic read_en;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic last_read;
   } dp_status_type;

endpackage

/* sv/bnlj_ctrl.sv */
module bnlj_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_cmd,
   input  bnlj_pkg::dp_status_type status,
   output logic                   busy,
   output bnlj_pkg::ctrl_cmd_type cmd
);
   import bnlj_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.clear = (req_cmd == CMD_CLEAR);
               cmd.load  = (req_cmd == CMD_LOAD);
               if (req_cmd == CMD_PROBE && !status.empty) begin
                  cmd.probe = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.read_en = 1'b1;
            if (status.last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/bnlj_dp.sv */
module bnlj_dp #(
   parameter int BLOCK_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bnlj_pkg::ctrl_cmd_type        cmd,
   input  logic [bnlj_pkg::RID_W-1:0]    req_in_rid,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_in_key,
   output bnlj_pkg::dp_status_type       status,
   output logic                          rsp_strobe,
   output logic [bnlj_pkg::RID_W-1:0]    rsp_match_r_rid,
   output logic [bnlj_pkg::RID_W-1:0]    rsp_match_s_rid,
   output logic                          rsp_last_match
);
   import bnlj_pkg::*;

   localparam int CNT_W  = $clog2(BLOCK_ENTRIES + 1);
   localparam int AW     = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
   localparam int WORD_W = RID_W + KEY_W;

   logic [WORD_W-1:0] mem [BLOCK_ENTRIES];

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  idx_in;
   logic [KEY_W-1:0]  probe_key_ff;
   logic [RID_W-1:0]  probe_rid_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic              pend_ff;
   logic              pend_in;
   logic [RID_W-1:0]  pend_rid_ff;
   logic [RID_W-1:0]  pend_rid_in;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   logic [RID_W-1:0]  rsp_r_rid_ff;
   logic [RID_W-1:0]  rsp_r_rid_in;
   logic [RID_W-1:0]  rsp_s_rid_ff;
   logic              rsp_last_ff;
   logic              rsp_last_in;
   logic              hit;
   logic              can_load;

   assign can_load         = (count_ff < CNT_W'(BLOCK_ENTRIES));
   assign status.empty     = (count_ff == '0);
   assign status.last_read = (idx_ff == count_ff - CNT_W'(1));
   assign hit = rd_valid_ff && (rd_data_ff[KEY_W-1:0] == probe_key_ff);

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_rid_in   = pend_rid_ff;
      rsp_strobe_in = 1'b0;
      rsp_r_rid_in  = pend_rid_ff;
      rsp_last_in   = 1'b0;
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.load && can_load) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.probe) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.read_en) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (hit) begin
         rsp_strobe_in = pend_ff;
         pend_in       = 1'b1;
         pend_rid_in   = rd_data_ff[WORD_W-1:KEY_W];
      end
      if (cmd.flush) begin
         rsp_strobe_in = pend_ff;
         rsp_last_in   = 1'b1;
         pend_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && can_load) begin
         mem[count_ff[AW-1:0]] <= {req_in_rid, req_in_key};
      end
      if (cmd.read_en) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= cmd.read_en;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe) begin
         probe_key_ff <= req_in_key;
         probe_rid_ff <= req_in_rid;
      end
      pend_rid_ff  <= pend_rid_in;
      rsp_r_rid_ff <= rsp_r_rid_in;
      rsp_s_rid_ff <= probe_rid_ff;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_match_r_rid = rsp_r_rid_ff;
   assign rsp_match_s_rid = rsp_s_rid_ff;
   assign rsp_last_match  = rsp_last_ff;

endmodule

/* sv/block_nested_loop_equijoin.sv */
// Block nested-loop equi-join engine for one block of relation R.
// An item is taken at a rising edge with start high and busy low. The item
// is a clear (empties the block), a load (appends one R row id and key,
// dropped once BLOCK_ENTRIES tuples are held) or a probe with one S tuple.
// Clear, load and unused command codes leave busy low and give no result.
// A probe on a block of N entries reads the block memory one entry a cycle,
// in load order, through its single registered read port, so busy stays high
// in the scan, drain and flush states; that port sets the read rate.
// Every stored key equal to the probe key gives one result on the rsp_
// ports, shown for exactly one cycle with rsp_strobe high. Results leave
// one match behind the scan, so the last one, marked by rsp_last_match,
// appears in the cycle busy falls. A probe with no match gives none.
// The receiver cannot stall the result channel and must take each result.
// Reset empties the block and returns the engine to idle; the stored
// tuples are not cleared and are never read before they are loaded.
module block_nested_loop_equijoin #(
   parameter int BLOCK_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_cmd,
   input  logic [bnlj_pkg::RID_W-1:0]        req_in_rid,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_in_key,
   output logic                              rsp_strobe,
   output logic [bnlj_pkg::RID_W-1:0]        rsp_match_r_rid,
   output logic [bnlj_pkg::RID_W-1:0]        rsp_match_s_rid,
   output logic                              rsp_last_match
);
   import bnlj_pkg::*;

   `include "block_nested_loop_equijoin_macros.svh"

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          probe_go;

   assign probe_go = start && !busy && (req_cmd == CMD_PROBE) && !status.empty;

   bnlj_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   bnlj_dp #(
      .BLOCK_ENTRIES (BLOCK_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_in_rid      (req_in_rid),
      .req_in_key      (req_in_key),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_match_r_rid (rsp_match_r_rid),
      .rsp_match_s_rid (rsp_match_s_rid),
      .rsp_last_match  (rsp_last_match)
   );

   `BNLJ_ASSERT_SAME(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `BNLJ_ASSERT_SAME(a_last_when_idle, clock, reset, rsp_strobe && rsp_last_match, !busy)
   `BNLJ_ASSERT_NEXT(a_probe_starts_scan, clock, reset, probe_go, busy)

endmodule
